/* rtl/core/aas_pkg.sv */
package aas_pkg;

    // operation codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_LOAD_AC = 3'd0,
        MODE_LOAD_MQ = 3'd1,
        MODE_ADD     = 3'd2,
        MODE_SUB     = 3'd3,
        MODE_MUL     = 3'd4,
        MODE_DIV     = 3'd5,
        MODE_DOUBLE  = 3'd6,
        MODE_HALVE   = 3'd7
    } t_mode;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PREP,
        ST_ITER,
        ST_FIX_Q,
        ST_FIX_R,
        ST_NEG,
        ST_DONE
    } t_state;

    // control of the shared adder: sum = a + (invert_b ? ~b : b) + carry_in
    typedef struct packed {
        logic invert_b;
        logic carry_in;
    } t_add_ctl;

endpackage

/* rtl/core/aas_if.sv */
interface aas_in_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic [2:0]                  mode;
    logic signed [WORD_BITS-1:0] memory_word;
    logic                        negate;

    modport source (output valid, output mode, output memory_word, output negate,
                    input ready);
    modport sink   (input valid, input mode, input memory_word, input negate,
                    output ready);
endinterface

interface aas_out_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] accumulator_out;
    logic signed [WORD_BITS-1:0] mq_out;
    logic                        divide_by_zero;

    modport source (output valid, output accumulator_out, output mq_out,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input accumulator_out, input mq_out,
                    input divide_by_zero, output ready);
endinterface

/* rtl/core/accumulator_alu_step_unit.sv */
// accumulator alu step unit
// channels: i_item (sink) takes one transaction per step with mode, memory_word
// and negate; o_result (source) returns one transaction per step with the
// accumulator and mq after the step and a divide-by-zero flag. both channels
// move a transaction on a clock edge where valid and ready are high.
//
// one shared adder of WORD_BITS+1 bits does all arithmetic under a small
// sequencer; i_item.ready is high only while the sequencer is idle.
// states from acceptance until o_result.valid rises:
//   load ac, load mq, double, halve, add/sub, div by 0 : exec, done
//   add/sub with negate                                : exec, neg, done
//   multiply (shift-add, one multiplier bit/cycle)     : exec, iter, done
//   divide (restoring, one quotient bit/cycle)         : exec, prep, iter, fix_q, fix_r, done
// a new item is accepted at the earliest the cycle after the result is loaded;
// the sequencer takes no item while it is still busy with the last one.
//
// reset (synchronous, active low) clears ac and mq to zero, empties the
// result register and returns the sequencer to idle. a stalled receiver
// leaves the finished result in the output register; the block accepts the
// next item meanwhile and only waits when that item's result is ready.
module accumulator_alu_step_unit
    import aas_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aas_in_if.sink     i_item,
    aas_out_if.source  o_result
);

    localparam int AW    = WORD_BITS + 1;
    localparam int CNT_W = $clog2(WORD_BITS);

    // sequencer and architectural state
    t_state               r_state, n_state;
    logic [WORD_BITS-1:0] r_ac, n_ac;
    logic [WORD_BITS-1:0] r_mq, n_mq;

    // captured transaction
    t_mode                r_mode;
    logic                 r_negate;
    logic [WORD_BITS-1:0] r_mem;

    // working registers: multiplicand/dividend-quotient, multiplier/divisor,
    // partial product/partial remainder
    logic [WORD_BITS-1:0] r_x, n_x;
    logic [WORD_BITS-1:0] r_y, n_y;
    logic [WORD_BITS-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_qneg, n_qneg;
    logic                 r_rneg, n_rneg;
    logic                 r_dbz, n_dbz;

    // output register
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_ac;
    logic [WORD_BITS-1:0] r_out_mq;
    logic                 r_out_dbz;

    // shared adder
    logic [AW-1:0]        add_a, add_b, add_sum;
    t_add_ctl             add_ctl;
    logic [WORD_BITS-1:0] sum_lo;

    logic                 in_accept;
    logic                 out_free;
    logic                 iter_last;
    logic [AW-1:0]        div_shift;
    logic                 div_ge;
    logic [WORD_BITS-1:0] mul_prod;

    assign in_accept = i_item.valid && i_item.ready;
    assign out_free  = !r_out_valid || o_result.ready;
    assign iter_last = (r_cnt == CNT_W'(WORD_BITS - 1));
    assign sum_lo    = add_sum[WORD_BITS-1:0];

    // restoring divide: shift in the next dividend bit, then trial subtract
    assign div_shift = {r_rem, r_x[WORD_BITS-1]};
    assign div_ge    = !add_sum[WORD_BITS];
    // shift-add multiply keeps only the low word, which wraps correctly
    assign mul_prod  = r_y[0] ? sum_lo : r_rem;

    aas_addsub #(
        .WIDTH (AW)
    ) u_addsub (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_ctl (add_ctl),
        .o_sum (add_sum)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_mode) inside
                    MODE_ADD, MODE_SUB: n_state = r_negate ? ST_NEG : ST_DONE;
                    MODE_MUL:           n_state = ST_ITER;
                    MODE_DIV:           n_state = (r_ac == '0) ? ST_DONE : ST_PREP;
                    default:            n_state = ST_DONE;
                endcase
            end
            ST_PREP:  n_state = ST_ITER;
            ST_ITER: begin
                if (iter_last) begin
                    n_state = (r_mode == MODE_DIV) ? ST_FIX_Q : ST_DONE;
                end
            end
            ST_FIX_Q: n_state = ST_FIX_R;
            ST_FIX_R: n_state = ST_DONE;
            ST_NEG:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // adder operand selection; negation is 0 + ~b + 1
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_ctl = '0;
        unique case (r_state)
            ST_EXEC: begin
                unique case (r_mode)
                    MODE_LOAD_AC: begin
                        add_b   = {1'b0, r_mem};
                        add_ctl = '{invert_b: r_negate, carry_in: r_negate};
                    end
                    MODE_ADD: begin
                        add_a = {1'b0, r_mem};
                        add_b = {1'b0, r_ac};
                    end
                    MODE_SUB: begin
                        add_a   = {1'b0, r_mem};
                        add_b   = {1'b0, r_ac};
                        add_ctl = '{invert_b: 1'b1, carry_in: 1'b1};
                    end
                    MODE_DIV: begin
                        // magnitude of the dividend
                        add_b   = {1'b0, r_mem};
                        add_ctl = '{invert_b: 1'b1, carry_in: 1'b1};
                    end
                    MODE_DOUBLE: begin
                        add_a = {1'b0, r_ac};
                        add_b = {1'b0, r_ac};
                    end
                    MODE_HALVE: begin
                        // bias negative values by one so the arithmetic
                        // shift truncates toward zero
                        add_a   = {1'b0, r_ac};
                        add_ctl = '{invert_b: 1'b0, carry_in: r_ac[WORD_BITS-1]};
                    end
                    default: begin
                        add_a = '0;
                    end
                endcase
            end
            ST_PREP: begin
                // magnitude of the divisor
                add_b   = {1'b0, r_ac};
                add_ctl = '{invert_b: 1'b1, carry_in: 1'b1};
            end
            ST_ITER: begin
                if (r_mode == MODE_DIV) begin
                    add_a   = div_shift;
                    add_b   = {1'b0, r_y};
                    add_ctl = '{invert_b: 1'b1, carry_in: 1'b1};
                end else begin
                    add_a = {1'b0, r_rem};
                    add_b = {1'b0, r_x};
                end
            end
            ST_FIX_Q: begin
                add_b   = {1'b0, r_x};
                add_ctl = '{invert_b: 1'b1, carry_in: 1'b1};
            end
            ST_FIX_R: begin
                add_b   = {1'b0, r_rem};
                add_ctl = '{invert_b: 1'b1, carry_in: 1'b1};
            end
            ST_NEG: begin
                add_b   = {1'b0, r_ac};
                add_ctl = '{invert_b: 1'b1, carry_in: 1'b1};
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_ac   = r_ac;
        n_mq   = r_mq;
        n_x    = r_x;
        n_y    = r_y;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_qneg = r_qneg;
        n_rneg = r_rneg;
        n_dbz  = r_dbz;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_dbz = 1'b0;
                end
            end
            ST_EXEC: begin
                unique case (r_mode) inside
                    MODE_LOAD_AC, MODE_ADD, MODE_SUB, MODE_DOUBLE: begin
                        n_ac = sum_lo;
                    end
                    MODE_LOAD_MQ: begin
                        n_mq = r_mem;
                    end
                    MODE_MUL: begin
                        n_x   = r_mem;
                        n_y   = r_ac;
                        n_rem = '0;
                        n_cnt = '0;
                    end
                    MODE_DIV: begin
                        if (r_ac == '0) begin
                            n_dbz = 1'b1;
                        end else begin
                            n_qneg = r_mem[WORD_BITS-1] ^ r_ac[WORD_BITS-1];
                            n_rneg = r_mem[WORD_BITS-1];
                            n_x    = r_mem[WORD_BITS-1] ? sum_lo : r_mem;
                        end
                    end
                    MODE_HALVE: begin
                        n_ac = {sum_lo[WORD_BITS-1], sum_lo[WORD_BITS-1:1]};
                    end
                    default: begin
                        n_ac = r_ac;
                    end
                endcase
            end
            ST_PREP: begin
                n_y   = r_ac[WORD_BITS-1] ? sum_lo : r_ac;
                n_rem = '0;
                n_cnt = '0;
            end
            ST_ITER: begin
                n_cnt = r_cnt + 1'b1;
                if (r_mode == MODE_DIV) begin
                    n_rem = div_ge ? sum_lo : div_shift[WORD_BITS-1:0];
                    n_x   = {r_x[WORD_BITS-2:0], div_ge};
                end else begin
                    n_rem = mul_prod;
                    n_x   = {r_x[WORD_BITS-2:0], 1'b0};
                    n_y   = {1'b0, r_y[WORD_BITS-1:1]};
                    if (iter_last) begin
                        n_ac = mul_prod;
                    end
                end
            end
            ST_FIX_Q: n_ac = r_qneg ? sum_lo : r_x;
            ST_FIX_R: n_mq = r_rneg ? sum_lo : r_rem;
            ST_NEG:   n_ac = sum_lo;
            default: begin
                n_ac = r_ac;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ac        <= '0;
            r_mq        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ac    <= n_ac;
            r_mq    <= n_mq;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode   <= t_mode'(i_item.mode);
            r_negate <= i_item.negate;
            r_mem    <= i_item.memory_word;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
        r_dbz  <= n_dbz;
        if (r_state == ST_DONE && out_free) begin
            r_out_ac  <= r_ac;
            r_out_mq  <= r_mq;
            r_out_dbz <= r_dbz;
        end
    end

    assign i_item.ready             = (r_state == ST_IDLE);
    assign o_result.valid           = r_out_valid;
    assign o_result.accumulator_out = r_out_ac;
    assign o_result.mq_out          = r_out_mq;
    assign o_result.divide_by_zero  = r_out_dbz;

endmodule

/* rtl/core/aas_addsub.sv */
module aas_addsub
    import aas_pkg::*;
#(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  t_add_ctl         i_ctl,
    output logic [WIDTH-1:0] o_sum
);

    logic [WIDTH-1:0] b_eff;

    assign b_eff = i_ctl.invert_b ? ~i_b : i_b;
    assign o_sum = i_a + b_eff + WIDTH'(i_ctl.carry_in);

endmodule

/* rtl/core/aas_checker.sv */
module aas_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [WORD_BITS-1:0] i_acc,
    input logic [WORD_BITS-1:0] i_mq,
    input logic                 i_dbz
);

    logic [WORD_BITS-1:0] r_last_ac;
    logic [WORD_BITS-1:0] r_last_mq;

    // registers as of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ac <= '0;
            r_last_mq <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_ac <= i_acc;
            r_last_mq <= i_mq;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_acc) && $stable(i_mq) && $stable(i_dbz))
        else $error("result payload changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready still high after taking a transaction");

    a_dbz_keeps_regs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dbz |-> i_acc == r_last_ac && i_mq == r_last_mq)
        else $error("divide by zero changed ac or mq");

endmodule

bind accumulator_alu_step_unit aas_checker #(
    .WORD_BITS (WORD_BITS)
) u_aas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_acc       (o_result.accumulator_out),
    .i_mq        (o_result.mq_out),
    .i_dbz       (o_result.divide_by_zero)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import aas_pkg::*;

    localparam int WORD_BITS   = 32;
    localparam int ITEM_TARGET = 500;
    localparam int DRAIN_WAIT  = WORD_BITS + 20;  // longest step is divide
    localparam int HOLD_CYCLES = 400;             // long receiver hold-off
    localparam int HOLD_AFTER  = 150;             // results seen before the hold-off starts

    typedef logic [WORD_BITS-1:0] word_t;

    // accumulator and mq after one step, as the result channel reports them
    typedef struct packed {
        word_t acc;
        word_t mq;
        logic  dbz;
    } ac_mq_t;

    // tracks ac and mq across steps and holds the register values still owed
    class ac_mq_ledger;
        word_t  ac_reg;
        word_t  mq_reg;
        ac_mq_t pending_regs[$];
        int     errors;
        int     checked;
        int     mode_hits[8];
        int     dbz_hits;

        function new();
            ac_reg  = '0;
            mq_reg  = '0;
            errors  = 0;
            checked = 0;
            dbz_hits = 0;
            foreach (mode_hits[i]) mode_hits[i] = 0;
        endfunction

        // advance the registers by one accepted transaction
        function void apply_step(t_mode mode, word_t word, logic neg);
            word_t  ac;
            word_t  mq;
            word_t  mag_w;
            word_t  mag_a;
            word_t  quo;
            word_t  rem;
            word_t  half;
            logic   dbz;
            ac_mq_t regs;
            ac  = ac_reg;
            mq  = mq_reg;
            dbz = 1'b0;
            case (mode)
                MODE_LOAD_AC: ac = neg ? -word : word;
                MODE_LOAD_MQ: mq = word;
                MODE_ADD: begin
                    ac = word + ac;
                    if (neg) ac = -ac;
                end
                MODE_SUB: begin
                    ac = word - ac;
                    if (neg) ac = -ac;
                end
                MODE_MUL: ac = word * ac;
                MODE_DIV: begin
                    if (ac == '0) begin
                        dbz = 1'b1;
                    end else begin
                        // magnitudes, then signs: quotient toward zero, remainder follows M(X)
                        mag_w = word[WORD_BITS-1] ? -word : word;
                        mag_a = ac[WORD_BITS-1] ? -ac : ac;
                        quo   = mag_w / mag_a;
                        rem   = mag_w % mag_a;
                        if (word[WORD_BITS-1] != ac[WORD_BITS-1]) quo = -quo;
                        if (word[WORD_BITS-1]) rem = -rem;
                        ac = quo;
                        mq = rem;
                    end
                end
                MODE_DOUBLE: ac = ac << 1;
                default: begin
                    // halve toward zero
                    half = (ac[WORD_BITS-1] ? -ac : ac) >> 1;
                    ac   = ac[WORD_BITS-1] ? -half : half;
                end
            endcase
            ac_reg = ac;
            mq_reg = mq;
            mode_hits[mode]++;
            if (dbz) dbz_hits++;
            regs.acc = ac;
            regs.mq  = mq;
            regs.dbz = dbz;
            pending_regs.push_back(regs);
        endfunction

        function void compare_step(word_t acc, word_t mq, logic dbz);
            ac_mq_t want;
            if (pending_regs.size() == 0) begin
                $display("%0t: result transaction with nothing outstanding: acc %h mq %h dbz %b",
                         $time, acc, mq, dbz);
                errors++;
                return;
            end
            want = pending_regs.pop_front();
            checked++;
            if (acc !== want.acc) begin
                $display("%0t: accumulator_out expected %h actual %h", $time, want.acc, acc);
                errors++;
            end
            if (mq !== want.mq) begin
                $display("%0t: mq_out expected %h actual %h", $time, want.mq, mq);
                errors++;
            end
            if (dbz !== want.dbz) begin
                $display("%0t: divide_by_zero expected %b actual %b", $time, want.dbz, dbz);
                errors++;
            end
        endfunction

        function void flush_leftover();
            if (pending_regs.size() != 0) begin
                $display("%0t: %0d result transactions never arrived", $time,
                         pending_regs.size());
                errors += pending_regs.size();
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    aas_in_if  #(.WORD_BITS(WORD_BITS)) item_if ();
    aas_out_if #(.WORD_BITS(WORD_BITS)) result_if ();

    accumulator_alu_step_unit #(
        .WORD_BITS(WORD_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    ac_mq_ledger ledger = new();

    int items_sent;
    int burst_left;
    int results_seen;
    int hold_left;
    bit hold_done;
    int style_left;
    int ready_style;

    initial i_clk = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // offer one transaction and wait until the block takes it
    task automatic send_item(input t_mode mode, input word_t word, input logic neg);
        item_if.valid       <= 1'b1;
        item_if.mode        <= mode;
        item_if.memory_word <= word;
        item_if.negate      <= neg;
        do @(posedge i_clk); while (!item_if.ready);
        ledger.apply_step(mode, word, neg);
    endtask

    task automatic hold_sender(input int cycles);
        item_if.valid       <= 1'b0;
        item_if.memory_word <= $urandom;  // junk payload while idle
        repeat (cycles) @(posedge i_clk);
    endtask

    // bursts of random length, random gaps between them
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) hold_sender($urandom_range(1, 8));
        end
        burst_left--;
    endtask

    function automatic word_t pick_word();
        word_t w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = $urandom;
            4, 5:       w = $urandom_range(0, 64) - 32;
            6: begin
                case ($urandom_range(0, 3))
                    0:       w = {1'b1, {(WORD_BITS-1){1'b0}}};
                    1:       w = {1'b0, {(WORD_BITS-1){1'b1}}};
                    2:       w = '1;
                    default: w = word_t'(1);
                endcase
            end
            7:       w = word_t'(1) << $urandom_range(0, WORD_BITS - 1);
            8:       w = '0;
            default: w = -(word_t'(1) << $urandom_range(0, WORD_BITS - 1));
        endcase
        return w;
    endfunction

    // receiver: changing ready patterns, one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (result_if.valid && result_if.ready) begin
            ledger.compare_step(result_if.accumulator_out, result_if.mq_out,
                                result_if.divide_by_zero);
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_if.ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            result_if.ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                style_left  = $urandom_range(16, 128);
                ready_style = $urandom_range(0, 2);
            end
            style_left--;
            case (ready_style)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= 1'($urandom_range(0, 1));
                default: result_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        #5_000_000;
        $display("accumulator_alu_step_unit: mismatch");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        item_if.valid       = 1'b0;
        item_if.mode        = MODE_LOAD_AC;
        item_if.memory_word = '0;
        item_if.negate      = 1'b0;
        result_if.ready     = 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        results_seen = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        style_left   = 0;
        ready_style  = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, wrap-around, sign handling, divide corner cases
        send_item(MODE_LOAD_AC, 32'h7FFF_FFFF, 1'b0);
        send_item(MODE_DOUBLE, 32'h0000_0000, 1'b1);   // wraps, negate ignored
        send_item(MODE_HALVE, 32'hFFFF_FFFF, 1'b0);    // -2 -> -1
        send_item(MODE_HALVE, 32'hFFFF_FFFF, 1'b1);    // -1 -> 0, toward zero
        send_item(MODE_DIV, 32'h0000_1234, 1'b0);      // divide by zero
        send_item(MODE_LOAD_AC, 32'h8000_0000, 1'b1);  // negating most negative
        send_item(MODE_HALVE, 32'h0000_0000, 1'b1);
        send_item(MODE_LOAD_AC, 32'h8000_0000, 1'b0);
        send_item(MODE_ADD, 32'h8000_0000, 1'b0);      // overflow to zero
        send_item(MODE_LOAD_AC, 32'h0000_0001, 1'b1);
        send_item(MODE_DIV, 32'h8000_0000, 1'b0);      // most negative by minus one
        send_item(MODE_SUB, 32'h7FFF_FFFF, 1'b0);
        send_item(MODE_SUB, 32'h0000_0005, 1'b1);
        send_item(MODE_ADD, 32'h7FFF_FFFF, 1'b1);
        send_item(MODE_LOAD_MQ, 32'hFFFF_FFFF, 1'b1);  // negate ignored
        send_item(MODE_LOAD_AC, 32'd7, 1'b0);
        send_item(MODE_DIV, -32'sd23, 1'b0);           // remainder follows dividend
        send_item(MODE_LOAD_AC, -32'sd7, 1'b0);
        send_item(MODE_DIV, 32'd23, 1'b1);
        send_item(MODE_LOAD_AC, -32'sd7, 1'b0);
        send_item(MODE_DIV, -32'sd23, 1'b0);
        send_item(MODE_LOAD_AC, 32'h7FFF_FFFF, 1'b0);
        send_item(MODE_MUL, 32'h7FFF_FFFF, 1'b1);
        send_item(MODE_MUL, 32'h8000_0000, 1'b0);
        send_item(MODE_DIV, 32'h0000_0000, 1'b0);      // zero dividend

        // random: single steps plus load-then-operate pairs
        while (items_sent < ITEM_TARGET) begin
            pace_sender();
            if ($urandom_range(0, 9) < 3) begin
                send_item(MODE_LOAD_AC, pick_word(), 1'($urandom_range(0, 1)));
                pace_sender();
                send_item(t_mode'($urandom_range(2, 7)), pick_word(),
                          1'($urandom_range(0, 1)));
                items_sent += 2;
            end else begin
                send_item(t_mode'($urandom_range(0, 7)), pick_word(),
                          1'($urandom_range(0, 1)));
                items_sent++;
            end
        end
        item_if.valid <= 1'b0;

        while (ledger.pending_regs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        ledger.flush_leftover();

        $display("covered %0d steps: ldac %0d ldmq %0d add %0d sub %0d mul %0d div %0d",
                 ledger.checked, ledger.mode_hits[MODE_LOAD_AC], ledger.mode_hits[MODE_LOAD_MQ],
                 ledger.mode_hits[MODE_ADD], ledger.mode_hits[MODE_SUB],
                 ledger.mode_hits[MODE_MUL], ledger.mode_hits[MODE_DIV]);
        $display("double %0d halve %0d, divide by zero %0d, one %0d-cycle receiver hold-off",
                 ledger.mode_hits[MODE_DOUBLE], ledger.mode_hits[MODE_HALVE],
                 ledger.dbz_hits, HOLD_CYCLES);
        if (ledger.errors == 0) begin
            $display("accumulator_alu_step_unit: match");
        end else begin
            $display("accumulator_alu_step_unit: mismatch");
        end
        $finish;
    end

endmodule
